// ===== hw/rtl/kl_pkg.sv =====
// shared constants for the koren limiter reconstruction pipeline
`timescale 1ns / 1ps
package kl_pkg;
  // the quotient is built this many bits per divider stage
  localparam int CHUNK_W = 16;
  // divide by three: q = (v * DIV3_MUL) >> DIV3_SHIFT, exact for v < 2**DIV3_SHIFT
  localparam int DIV3_SHIFT = CHUNK_W + 3;
  localparam int MUL_W = CHUNK_W + 2;
  localparam logic [MUL_W-1:0] DIV3_MUL = MUL_W'(((1 << DIV3_SHIFT) + 2) / 3);
endpackage

// ===== hw/rtl/koren_limited_face_reconstruction.sv =====
// top level: koren-limited muscl face reconstruction pipeline
`timescale 1ns / 1ps
// path: stages 1 to 4, the divider stages, stage 5 and the output register (stage 6);
// the chunked divide-by-three sets the depth
// throughput: one transfer per cycle, the whole pipeline advances together
// and freezes only while the output register holds an untaken result
// reset: synchronous active-low rst_n clears all stage valid bits
module koren_limited_face_reconstruction #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_prev_value,
  input  logic signed [DATA_WIDTH-1:0] in_centre_value,
  input  logic signed [DATA_WIDTH-1:0] in_next_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_left_face,
  output logic signed [DATA_WIDTH-1:0] out_right_face
);
  import kl_pkg::*;

  localparam int DW     = DATA_WIDTH;
  localparam int SIDE_W = 2 + 2 * DW;

  // global advance: move when the output slot is free or being taken
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: offset-binary differences (sign flip makes unsigned order signed)
  logic          v1_r;
  logic [DW:0]   dfw1_r, dbw1_r;
  logic [DW-1:0] b1_r;
  logic [DW-1:0] ao, bo, co;
  always_comb begin
    ao = in_prev_value   ^ {1'b1, {(DW-1){1'b0}}};
    bo = in_centre_value ^ {1'b1, {(DW-1){1'b0}}};
    co = in_next_value   ^ {1'b1, {(DW-1){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid && in_ready;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dfw1_r <= {1'b0, co} - {1'b0, bo};
      dbw1_r <= {1'b0, bo} - {1'b0, ao};
      b1_r   <= in_centre_value;
    end
  end

  // stage 2: classify and take magnitudes
  logic          v2_r, rising2_r, flat2_r;
  logic [DW-1:0] fwd2_r, bwd2_r, b2_r;
  logic          rising_nxt, falling_nxt;
  always_comb begin
    rising_nxt  = !dfw1_r[DW] && (dfw1_r != '0) && !dbw1_r[DW] && (dbw1_r != '0);
    falling_nxt = dfw1_r[DW] && dbw1_r[DW];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rising2_r <= rising_nxt;
      flat2_r   <= !(rising_nxt || falling_nxt);
      fwd2_r    <= dfw1_r[DW] ? DW'(-dfw1_r) : dfw1_r[DW-1:0];
      bwd2_r    <= dbw1_r[DW] ? DW'(-dbw1_r) : dbw1_r[DW-1:0];
      b2_r      <= b1_r;
    end
  end

  // stage 3: smaller and larger difference magnitude
  logic          v3_r, rising3_r, flat3_r;
  logic [DW-1:0] m3_r, big3_r, b3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rising3_r <= rising2_r;
      flat3_r   <= flat2_r;
      m3_r      <= (fwd2_r < bwd2_r) ? fwd2_r : bwd2_r;
      big3_r    <= (fwd2_r < bwd2_r) ? bwd2_r : fwd2_r;
      b3_r      <= b2_r;
    end
  end

  // stage 4: floor((2m + M) / 2) = m + floor(M / 2), later divided by three
  logic          v4_r, rising4_r, flat4_r;
  logic [DW:0]   t4_r;
  logic [DW-1:0] m4_r, b4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rising4_r <= rising3_r;
      flat4_r   <= flat3_r;
      t4_r      <= {1'b0, m3_r} + {2'b00, big3_r[DW-1:1]};
      m4_r      <= m3_r;
      b4_r      <= b3_r;
    end
  end

  // divider stages: q = floor((2m + M) / 6)
  logic              vd;
  logic [DW:0]       qd;
  logic [SIDE_W-1:0] sided;
  kl_div3_pipe #(
    .TW     (DW + 1),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v4_r),
    .in_t      (t4_r),
    .in_side   ({flat4_r, rising4_r, b4_r, m4_r}),
    .out_valid (vd),
    .out_q     (qd),
    .out_side  (sided)
  );

  logic          flat_d, rising_d;
  logic [DW-1:0] b_d, m_d;
  assign {flat_d, rising_d, b_d, m_d} = sided;

  // stage 5: half slope magnitude, limited by the smaller difference
  logic          v5_r, rising5_r, flat5_r;
  logic [DW-1:0] h5_r, b5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= vd;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rising5_r <= rising_d;
      flat5_r   <= flat_d;
      h5_r      <= ({1'b0, m_d} < qd) ? m_d : qd[DW-1:0];
      b5_r      <= b_d;
    end
  end

  // stage 6: output register, faces straddle the centre
  logic          out_valid_r;
  logic [DW-1:0] left_r, right_r;
  logic [DW-1:0] plus_h, minus_h;
  assign plus_h  = b5_r + h5_r;
  assign minus_h = b5_r - h5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v5_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (flat5_r) begin
        left_r  <= b5_r;
        right_r <= b5_r;
      end else if (rising5_r) begin
        left_r  <= plus_h;
        right_r <= minus_h;
      end else begin
        left_r  <= minus_h;
        right_r <= plus_h;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_left_face  = left_r;
  assign out_right_face = right_r;
endmodule

// ===== hw/rtl/kl_div3_pipe.sv =====
// pipelined divide-by-three, one quotient chunk per stage, with sideband
`timescale 1ns / 1ps
module kl_div3_pipe #(
  parameter int TW     = 33,
  parameter int SIDE_W = 66
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [TW-1:0]     in_t,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [TW-1:0]     out_q,
  output logic [SIDE_W-1:0] out_side
);
  import kl_pkg::*;

  localparam int NCH  = (TW + CHUNK_W - 1) / CHUNK_W;
  localparam int PW   = NCH * CHUNK_W;
  localparam int VW   = CHUNK_W + 2;
  localparam int PRDW = VW + MUL_W;

  logic              v_r    [NCH];
  logic [PW-1:0]     t_r    [NCH];
  logic [PW-1:0]     q_r    [NCH];
  logic [1:0]        rem_r  [NCH];
  logic [SIDE_W-1:0] side_r [NCH];

  genvar k;
  generate
    for (k = 0; k < NCH; k++) begin : g_stage
      logic              v_in;
      logic [PW-1:0]     t_in;
      logic [PW-1:0]     q_in;
      logic [1:0]        rem_in;
      logic [SIDE_W-1:0] side_in;
      logic [VW-1:0]     val;
      logic [PRDW-1:0]   prod;
      logic [CHUNK_W-1:0] qc;
      logic [VW-1:0]     back;
      logic [PW-1:0]     q_nxt;
      logic [1:0]        rem_nxt;

      if (k == 0) begin : g_first
        assign v_in    = in_valid;
        assign t_in    = PW'(in_t);
        assign q_in    = '0;
        assign rem_in  = 2'd0;
        assign side_in = in_side;
      end else begin : g_rest
        assign v_in    = v_r[k-1];
        assign t_in    = t_r[k-1];
        assign q_in    = q_r[k-1];
        assign rem_in  = rem_r[k-1];
        assign side_in = side_r[k-1];
      end

      always_comb begin
        val  = {rem_in, t_in[PW-1-k*CHUNK_W -: CHUNK_W]};
        prod = PRDW'(val) * PRDW'(DIV3_MUL);
        qc   = prod[DIV3_SHIFT +: CHUNK_W];
        back = VW'({qc, 1'b0}) + VW'(qc);
        rem_nxt = 2'(val - back);
        q_nxt = q_in;
        q_nxt[PW-1-k*CHUNK_W -: CHUNK_W] = qc;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          t_r[k]    <= t_in;
          q_r[k]    <= q_nxt;
          rem_r[k]  <= rem_nxt;
          side_r[k] <= side_in;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[NCH-1];
  assign out_q     = q_r[NCH-1][TW-1:0];
  assign out_side  = side_r[NCH-1];
endmodule

// ===== dv/koren_face_checker.sv =====
// checker: predicts koren-limited faces from input transfers and compares results
`timescale 1ns / 1ps
module koren_face_checker #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_prev_value,
  input  logic signed [DATA_WIDTH-1:0] in_centre_value,
  input  logic signed [DATA_WIDTH-1:0] in_next_value,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic signed [DATA_WIDTH-1:0] out_left_face,
  input  logic signed [DATA_WIDTH-1:0] out_right_face,
  output int                           fail_count,
  output int                           pending_faces,
  output int                           face_count
);
  typedef struct packed {
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;
  } face_pair_t;

  face_pair_t expected_faces[$];

  function automatic face_pair_t koren_faces(logic [DATA_WIDTH-1:0] p,
                                             logic [DATA_WIDTH-1:0] c,
                                             logic [DATA_WIDTH-1:0] n);
    logic signed [DATA_WIDTH:0] sp, sc, sn;
    logic [DATA_WIDTH+3:0] fwd, bwd, lo, hi, half;
    face_pair_t f;
    sp = $signed(p);
    sc = $signed(c);
    sn = $signed(n);
    f.left = c;
    f.right = c;
    if ((sn > sc && sc > sp) || (sn < sc && sc < sp)) begin
      fwd = (sn > sc) ? sn - sc : sc - sn;
      bwd = (sc > sp) ? sc - sp : sp - sc;
      lo = (fwd < bwd) ? fwd : bwd;
      hi = (fwd < bwd) ? bwd : fwd;
      half = (2 * lo + hi) / 6;
      if (lo < half) half = lo;
      if (sn > sc) begin
        f.left = c + half[DATA_WIDTH-1:0];
        f.right = c - half[DATA_WIDTH-1:0];
      end else begin
        f.left = c - half[DATA_WIDTH-1:0];
        f.right = c + half[DATA_WIDTH-1:0];
      end
    end
    return f;
  endfunction

  assign pending_faces = expected_faces.size();

  always @(posedge clk) begin
    face_pair_t want;
    if (!rst_n) begin
      fail_count <= 0;
      face_count <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_faces.push_back(koren_faces(in_prev_value, in_centre_value, in_next_value));
      if (out_valid && out_ready) begin
        face_count <= face_count + 1;
        if (expected_faces.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h %h", out_left_face, out_right_face);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_faces.pop_front();
          if (want.left !== out_left_face || want.right !== out_right_face) begin
            if (fail_count < 10)
              $display("face mismatch: left exp %h got %h, right exp %h got %h",
                       want.left, out_left_face, want.right, out_right_face);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== dv/testbench.sv =====
// testbench top: stimulus, handshake pressure and verdict for the face reconstruction
`timescale 1ns / 1ps
module testbench;
  localparam int DW = 32;
  localparam int CYCLE_LIMIT = 200000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [DW-1:0] in_prev_value, in_centre_value, in_next_value;
  logic signed [DW-1:0] out_left_face, out_right_face;
  int fail_count, pending_faces, face_count;
  int cycle_count;
  // receiver pressure controls
  bit hold_off;
  bit calm_out;
  int sent_items;

  koren_limited_face_reconstruction #(.DATA_WIDTH(DW)) dut (.*);

  koren_face_checker #(.DATA_WIDTH(DW)) checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // generous watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, a calm stretch, and a long hold-off when asked
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 0;
    else if (hold_off) out_ready <= 0;
    else if (calm_out) out_ready <= 1;
    else out_ready <= ($urandom_range(99) >= 19);
  end

  // one transfer: hold valid until the handshake lands
  task automatic send_cells(logic [DW-1:0] p, logic [DW-1:0] c, logic [DW-1:0] n,
                            bit may_idle);
    while (may_idle && $urandom_range(99) < 19) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_prev_value <= p;
    in_centre_value <= c;
    in_next_value <= n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent_items++;
  endtask

  // mostly monotone triples so the limiter path dominates, with spreads at many scales
  task automatic random_triple(output logic [DW-1:0] p, c, n);
    int kind;
    logic [DW-1:0] step1, step2;
    kind = $urandom_range(9);
    c = $urandom;
    step1 = $urandom >> $urandom_range(31);
    step2 = $urandom >> $urandom_range(31);
    if (kind < 7) begin
      // rising or falling, wrap allowed to give noise too
      if (kind < 4) begin
        p = c - step1;
        n = c + step2;
      end else begin
        p = c + step1;
        n = c - step2;
      end
    end else begin
      p = $urandom;
      n = $urandom;
      if (kind == 9) n = c;
    end
  endtask

  initial begin
    logic [DW-1:0] p, c, n;
    logic [DW-1:0] corner[6];
    cycle_count = 0;
    hold_off = 0;
    calm_out = 0;
    sent_items = 0;
    in_valid = 0;
    in_prev_value = 0;
    in_centre_value = 0;
    in_next_value = 0;
    rst_n = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: extremes, flat, peaks, equal steps, ratio boundaries
    corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h0001_0000, 32'hffff_0000};
    send_cells(32'h8000_0000, 0, 32'h7fff_ffff, 0);
    send_cells(32'h7fff_ffff, 0, 32'h8000_0000, 0);
    send_cells(32'h8000_0000, 32'h7fff_fffe, 32'h7fff_ffff, 0);
    send_cells(32'h8000_0000, 32'h8000_0001, 32'h7fff_ffff, 0);
    send_cells(5, 5, 9, 0);
    send_cells(1, 5, 5, 0);
    send_cells(7, 7, 7, 0);
    send_cells(0, 10, 0, 0);
    send_cells(10, 0, 10, 0);
    send_cells(0, 6, 12, 0);
    send_cells(12, 6, 0, 0);
    send_cells(0, 1, 5, 0);
    send_cells(0, 4, 5, 0);
    send_cells(0, 1, 2, 0);
    send_cells(32'hfffe_0000, 32'hffff_0000, 32'h0001_0000, 0);
    send_cells(32'hffff_ffff, 0, 1, 0);
    for (int i = 0; i < 6; i++)
      send_cells(corner[i], corner[(i + 2) % 6], corner[(i + 4) % 6], 0);

    // calm stretch with no idling on either side
    calm_out = 1;
    for (int i = 0; i < 150; i++) begin
      random_triple(p, c, n);
      send_cells(p, c, n, 0);
    end
    calm_out = 0;

    // receiver holds off long while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (60) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 40; i++) begin
        random_triple(p, c, n);
        send_cells(p, c, n, 1);
      end
    join

    // sender drains the pipeline before carrying on
    in_valid <= 0;
    while (pending_faces != 0) @(negedge clk);

    for (int i = 0; i < 740; i++) begin
      random_triple(p, c, n);
      send_cells(p, c, n, 1);
    end
    in_valid <= 0;

    while (pending_faces != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("covered %0d triples, %0d face pairs checked, with stalls and a long hold-off",
             sent_items, face_count);
    if (fail_count == 0 && pending_faces == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== koren_limited_face_reconstruction.f =====
hw/rtl/kl_pkg.sv
hw/rtl/kl_div3_pipe.sv
hw/rtl/koren_limited_face_reconstruction.sv
dv/koren_face_checker.sv
dv/testbench.sv
